// ===== src/tqe_pkg.sv =====
// ----------------------------------------------------------------------------
// tqe_pkg
// Shared types and constants for the timer queue expiry engine.
// ----------------------------------------------------------------------------
package tqe_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int RESULT_CAP = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int FIRE_W     = $clog2(RESULT_CAP + 1);

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_DELETE    = 3'd1,
    OP_SET_TRIG  = 3'd2,
    OP_SET_PER   = 3'd3,
    OP_TICK      = 3'd4,
    OP_DEL_OWNER = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CREATE,
    CMD_DELETE,
    CMD_SET_TRIG,
    CMD_SET_PER,
    CMD_SNAP,
    CMD_FIRE,
    CMD_DEL_OWNER
  } cmd_op_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  slot;
    logic [31:0] time_value;
    logic [31:0] now;
    logic        repeat_flag;
    logic [7:0]  owner_id;
  } in_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_slot;
    logic [7:0]  fired_owner;
    logic [31:0] fired_trigger;
    logic        status;
    logic        last;
  } out_t;

  // Command broadcast to every cell.
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      tv;
    logic [31:0]      now;
    logic             rep;
    logic [7:0]       own;
    logic [31:0]      stamp;
  } cmd_t;

  // Best due slot seen so far, handed from cell to cell.
  typedef struct packed {
    logic             vld;
    logic [31:0]      trig;
    logic [31:0]      order;
    logic [IDX_W-1:0] idx;
    logic [7:0]       owner;
    logic             rep;
  } cand_t;

endpackage

// ===== src/tqe_cell.sv =====
// ----------------------------------------------------------------------------
// tqe_cell
// One timer slot: holds its state, applies broadcast commands and passes
// the better of its own due entry and the incoming candidate downstream.
// ----------------------------------------------------------------------------
module tqe_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tqe_pkg::IDX_W-1:0] cell_idx,
  input  tqe_pkg::cmd_t             cmd,
  input  tqe_pkg::cand_t            cand_in,
  output tqe_pkg::cand_t            cand_out,
  output logic                      valid
);
  import tqe_pkg::*;

  logic        due;
  logic [31:0] trig;
  logic [31:0] period;
  logic        rep;
  logic [7:0]  owner;
  logic [31:0] order;

  logic        hit;
  logic [31:0] addend;
  logic [32:0] sum;
  logic [31:0] sat;
  logic        mine_better;

  assign hit    = (cmd.idx == cell_idx);
  assign addend = (cmd.op == CMD_FIRE) ? ((period == 32'd0) ? 32'd1 : period) : cmd.tv;
  assign sum    = {1'b0, cmd.now} + {1'b0, addend};
  assign sat    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign mine_better = due && (!cand_in.vld || trig < cand_in.trig ||
                       (trig == cand_in.trig && order < cand_in.order));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      due          <= 1'b0;
      cand_out.vld <= 1'b0;
    end else begin
      if (mine_better) begin
        cand_out <= '{vld: 1'b1, trig: trig, order: order, idx: cell_idx,
                      owner: owner, rep: rep};
      end else begin
        cand_out <= cand_in;
      end
      case (cmd.op)
        CMD_CREATE: if (hit) begin
          valid  <= 1'b1;
          period <= cmd.tv;
          rep    <= cmd.rep;
          owner  <= cmd.own;
          trig   <= sat;
          order  <= cmd.stamp;
        end
        CMD_DELETE: if (hit) begin
          valid <= 1'b0;
        end
        CMD_SET_TRIG: if (hit && valid) begin
          trig  <= cmd.tv;
          order <= cmd.stamp;
        end
        CMD_SET_PER: if (hit && valid) begin
          period <= cmd.tv;
          trig   <= sat;
          order  <= cmd.stamp;
        end
        CMD_SNAP: begin
          due <= valid && (trig <= cmd.now);
        end
        CMD_FIRE: if (hit) begin
          due <= 1'b0;
          if (rep) begin
            trig  <= sat;
            order <= cmd.stamp;
          end else begin
            valid <= 1'b0;
          end
        end
        CMD_DEL_OWNER: if (valid && owner == cmd.own) begin
          valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/timer_queue_expiry_engine.sv =====
// ----------------------------------------------------------------------------
// timer_queue_expiry_engine
// Table of timer slots with ordered expiry, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// One item at a time. Create, delete, set and delete-by-owner items pass
// through the S_LAST state from accept to result. A tick searches the cell
// chain for the earliest due slot, and searches it again for every further
// expiry. The search time is set by the candidate passing one cell per
// cycle down the chain. Results are held in an output register, so
// a stalled consumer only delays the next expiry.
module timer_queue_expiry_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tqe_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tqe_pkg::out_t out_data
);
  import tqe_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST} state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  logic [FIRE_W-1:0]     nfired;
  logic [31:0]           now_q;
  logic [31:0]           arm_counter;
  logic                  have_pend;
  out_t                  pend;

  cmd_t                  cmd;
  cand_t                 chain [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] valid_vec;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  in_range;
  logic [IDX_W-1:0]      in_idx;
  logic                  live;
  logic                  scan_done;
  logic                  do_fire;
  logic                  bump;
  out_t                  found_res;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign in_range  = (32'(in_data.slot) < SLOT_COUNT);
  assign in_idx    = IDX_W'(in_data.slot);
  assign live      = in_range && valid_vec[in_idx];
  assign scan_done = (state == S_SCAN) && (cnt == CNT_W'(SLOT_COUNT));
  assign do_fire   = scan_done && chain[SLOT_COUNT].vld && (!have_pend || out_free);
  // Load the output register from the held result.
  assign out_load  = (do_fire && have_pend) || ((state == S_LAST) && out_free);

  // The expiry that fills the cap is the last result of its tick.
  assign found_res = '{fired: 1'b1, fired_slot: 4'(chain[SLOT_COUNT].idx),
                       fired_owner: chain[SLOT_COUNT].owner,
                       fired_trigger: chain[SLOT_COUNT].trig,
                       status: 1'b0,
                       last: (nfired == FIRE_W'(RESULT_CAP - 1))};

  // Decode the accepted item, or the expiry found by a scan, into a command.
  always_comb begin
    cmd       = '{op: CMD_NONE, idx: in_idx, tv: in_data.time_value,
                  now: in_data.now, rep: in_data.repeat_flag,
                  own: in_data.owner_id, stamp: arm_counter};
    bump      = 1'b0;
    if (accept) begin
      unique case (opcode_t'(in_data.opcode))
        OP_CREATE: begin
          if (in_range) begin
            cmd.op = CMD_CREATE;
            bump   = 1'b1;
          end
        end
        OP_DELETE:    if (live) cmd.op = CMD_DELETE;
        OP_SET_TRIG: begin
          if (live) begin
            cmd.op = CMD_SET_TRIG;
            bump   = 1'b1;
          end
        end
        OP_SET_PER: begin
          if (live) begin
            cmd.op = CMD_SET_PER;
            bump   = 1'b1;
          end
        end
        OP_TICK:      cmd.op = CMD_SNAP;
        OP_DEL_OWNER: cmd.op = CMD_DEL_OWNER;
        default:      cmd.op = CMD_NONE;
      endcase
    end else if (do_fire) begin
      cmd.op  = CMD_FIRE;
      cmd.idx = chain[SLOT_COUNT].idx;
      cmd.now = now_q;
      bump    = chain[SLOT_COUNT].rep;
    end
  end

  // Slot cells; an empty candidate enters at the head of the chain.
  assign chain[0] = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    tqe_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(g)),
      .cmd      (cmd),
      .cand_in  (chain[g]),
      .cand_out (chain[g+1]),
      .valid    (valid_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      nfired      <= '0;
      arm_counter <= '0;
      have_pend   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (bump) arm_counter <= arm_counter + 32'd1;
      out_valid <= out_load || (out_valid && !out_ready);

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode_t'(in_data.opcode) == OP_TICK) begin
              // Snapshot due slots, then search the chain.
              now_q     <= in_data.now;
              nfired    <= '0;
              cnt       <= '0;
              have_pend <= 1'b0;
              state     <= S_SCAN;
            end else begin
              pend      <= '{fired: 1'b0, fired_slot: 4'd0, fired_owner: 8'd0,
                             fired_trigger: 32'd0,
                             status: !((opcode_t'(in_data.opcode) == OP_DEL_OWNER) ||
                                       (in_data.opcode > 3'(OP_DEL_OWNER)) ||
                                       (opcode_t'(in_data.opcode) == OP_CREATE ?
                                        in_range : live)),
                             last: 1'b1};
              have_pend <= 1'b1;
              state     <= S_LAST;
            end
          end
        end
        S_SCAN: begin
          if (!scan_done) begin
            cnt <= cnt + CNT_W'(1);
          end else if (chain[SLOT_COUNT].vld) begin
            if (do_fire) begin
              // Release the previous expiry; it is known not to be the last.
              if (have_pend) begin
                out_data <= pend;
              end
              pend      <= found_res;
              have_pend <= 1'b1;
              nfired    <= nfired + FIRE_W'(1);
              cnt       <= '0;
              if (nfired == FIRE_W'(RESULT_CAP - 1)) begin
                state <= S_LAST;
              end
            end
          end else begin
            // Nothing more due: close out the tick.
            if (have_pend) begin
              pend.last <= 1'b1;
            end else begin
              pend      <= '{fired: 1'b0, fired_slot: 4'd0, fired_owner: 8'd0,
                             fired_trigger: 32'd0, status: 1'b0, last: 1'b1};
              have_pend <= 1'b1;
            end
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (out_free) begin
            out_data  <= pend;
            have_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fired_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.fired && out_data.status))
    else $error("expiry result carries nonzero status");

  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == CMD_FIRE |-> valid_vec[cmd.idx])
    else $error("fire issued to an empty slot");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    32'(nfired) <= RESULT_CAP)
    else $error("expiry count exceeds cap");

  a_cmd_last: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode_t'(in_data.opcode) != OP_TICK) |=> state == S_LAST && have_pend)
    else $error("command item did not queue its result");

endmodule

// ===== tb/sv/tqe_checker.sv =====
// ----------------------------------------------------------------------------
// tqe_checker
// Watches both channels, predicts timer expiries and compares each result.
// ----------------------------------------------------------------------------
module tqe_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  tqe_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  tqe_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count
);
  import tqe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        tbl_valid   [SLOT_COUNT];
  logic [31:0] tbl_trigger [SLOT_COUNT];
  logic [31:0] tbl_period  [SLOT_COUNT];
  logic        tbl_repeat  [SLOT_COUNT];
  logic [7:0]  tbl_owner   [SLOT_COUNT];
  logic [31:0] tbl_stamp   [SLOT_COUNT];
  logic [31:0] stamp_next;

  out_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic out_t blank_result(logic st);
    out_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // Update the slot table and queue the results of one accepted item.
  task automatic predict_expiries(in_t it);
    logic        due [SLOT_COUNT];
    logic        live, st;
    int          best, n;
    logic [31:0] p;
    out_t        r;
    out_t        batch[$];
    st   = 1'b0;
    n    = 0;
    live = (it.slot < SLOT_COUNT) && tbl_valid[it.slot];
    case (it.opcode)
      OP_CREATE: begin
        tbl_valid[it.slot]   = 1'b1;
        tbl_period[it.slot]  = it.time_value;
        tbl_repeat[it.slot]  = it.repeat_flag;
        tbl_owner[it.slot]   = it.owner_id;
        tbl_trigger[it.slot] = sat_sum(it.now, it.time_value);
        tbl_stamp[it.slot]   = stamp_next;
        stamp_next++;
      end
      OP_DELETE: begin
        if (live) tbl_valid[it.slot] = 1'b0; else st = 1'b1;
      end
      OP_SET_TRIG: begin
        if (live) begin
          tbl_trigger[it.slot] = it.time_value;
          tbl_stamp[it.slot]   = stamp_next;
          stamp_next++;
        end else st = 1'b1;
      end
      OP_SET_PER: begin
        if (live) begin
          tbl_period[it.slot]  = it.time_value;
          tbl_trigger[it.slot] = sat_sum(it.now, it.time_value);
          tbl_stamp[it.slot]   = stamp_next;
          stamp_next++;
        end else st = 1'b1;
      end
      OP_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++)
          due[i] = tbl_valid[i] && (tbl_trigger[i] <= it.now);
        while (n < RESULT_CAP) begin
          best = -1;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (due[i] && (best < 0 || tbl_trigger[i] < tbl_trigger[best] ||
                (tbl_trigger[i] == tbl_trigger[best] &&
                 tbl_stamp[i] < tbl_stamp[best])))
              best = i;
          end
          if (best < 0) break;
          due[best]       = 1'b0;
          r               = '0;
          r.fired         = 1'b1;
          r.fired_slot    = best[3:0];
          r.fired_owner   = tbl_owner[best];
          r.fired_trigger = tbl_trigger[best];
          batch.push_back(r);
          n++;
          if (tbl_repeat[best]) begin
            p = (tbl_period[best] == 0) ? 32'd1 : tbl_period[best];
            tbl_trigger[best] = sat_sum(it.now, p);
            tbl_stamp[best]   = stamp_next;
            stamp_next++;
          end else tbl_valid[best] = 1'b0;
        end
      end
      OP_DEL_OWNER: begin
        for (int i = 0; i < SLOT_COUNT; i++)
          if (tbl_valid[i] && tbl_owner[i] == it.owner_id) tbl_valid[i] = 1'b0;
      end
      default: ;
    endcase
    if (batch.size() == 0) batch.push_back(blank_result(st));
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) expected_results.push_back(batch[k]);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tbl_valid[i]   = 1'b0;
        tbl_trigger[i] = '0;
        tbl_period[i]  = '0;
        tbl_repeat[i]  = 1'b0;
        tbl_owner[i]   = '0;
        tbl_stamp[i]   = '0;
      end
      stamp_next = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      // Check the result side first; a new item never produces a result
      // in the same cycle it is accepted.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_expiries(in_data);
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the timer queue expiry engine: directed commands, then random
// item sequences with bursty idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import tqe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 434;
  // Slowest tick: 16 searches of the chain, each result stalled by the consumer.
  localparam longint CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending_count;
  logic calm = 1'b0;   // no idling near the end
  longint cycle_count = 0;
  logic [31:0] clock_now = 32'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timer_queue_expiry_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  tqe_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Give up on a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stall the result side in random bursts, or hold ready high.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Hold the item until it is accepted, after an optional idle burst.
  task automatic send_item(in_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic in_t make_item(opcode_t op, logic [3:0] s, logic [31:0] tv,
                                    logic [31:0] nw, logic rp, logic [7:0] own);
    in_t it;
    it.opcode = op; it.slot = s; it.time_value = tv;
    it.now = nw; it.repeat_flag = rp; it.owner_id = own;
    return it;
  endfunction

  // Time mostly advances; sometimes jumps anywhere, including the extremes.
  function automatic logic [31:0] pick_now();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      default: return clock_now + $urandom_range(0, 40);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t it;
    int  pick;
    it = '0;
    it.slot        = 4'($urandom_range(0, 15));
    it.repeat_flag = 1'($urandom_range(0, 1));
    it.owner_id    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    it.now         = pick_now();
    it.time_value  = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 30);
    pick = $urandom_range(0, 99);
    if      (pick < 35) it.opcode = OP_CREATE;
    else if (pick < 60) it.opcode = OP_TICK;
    else if (pick < 70) it.opcode = OP_DELETE;
    else if (pick < 80) it.opcode = OP_SET_TRIG;
    else if (pick < 88) it.opcode = OP_SET_PER;
    else if (pick < 95) it.opcode = OP_DEL_OWNER;
    else it.opcode = 3'($urandom_range(6, 7));
    if (it.opcode == OP_SET_TRIG && $urandom_range(0, 1))
      it.time_value = clock_now + $urandom_range(0, 30);
    return it;
  endfunction

  initial begin
    in_t it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-slot commands, extremes, zero period, saturation.
    send_item(make_item(OP_DELETE, 4'd3, '0, '0, 1'b0, 8'd0));
    send_item(make_item(OP_SET_TRIG, 4'd15, 32'd5, '0, 1'b0, 8'd0));
    send_item(make_item(OP_SET_PER, 4'd0, 32'd5, '0, 1'b0, 8'd0));
    send_item(make_item(OP_TICK, 4'd0, '0, 32'hFFFF_FFFF, 1'b0, 8'd0));
    send_item(make_item(opcode_t'(3'd6), 4'd0, '0, '0, 1'b0, 8'd0));
    send_item(make_item(opcode_t'(3'd7), 4'hF, '1, '1, 1'b1, 8'hFF));
    send_item(make_item(OP_CREATE, 4'd0, 32'd0, 32'd10, 1'b1, 8'hFF));
    send_item(make_item(OP_CREATE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b1, 8'd0));
    send_item(make_item(OP_CREATE, 4'd5, 32'd0, 32'd10, 1'b0, 8'd7));
    send_item(make_item(OP_CREATE, 4'd5, 32'd3, 32'd10, 1'b0, 8'd7));
    send_item(make_item(OP_TICK, 4'd0, '0, 32'd10, 1'b0, 8'd0));
    send_item(make_item(OP_TICK, 4'd0, '0, 32'd13, 1'b0, 8'd0));
    send_item(make_item(OP_SET_PER, 4'd15, 32'd0, 32'd20, 1'b0, 8'd0));
    send_item(make_item(OP_SET_TRIG, 4'd0, 32'hFFFF_FFFF, '0, 1'b0, 8'd0));
    send_item(make_item(OP_TICK, 4'd0, '0, 32'hFFFF_FFFF, 1'b0, 8'd0));
    send_item(make_item(OP_DEL_OWNER, 4'd0, '0, '0, 1'b0, 8'd99));
    send_item(make_item(OP_DEL_OWNER, 4'd0, '0, '0, 1'b0, 8'hFF));
    send_item(make_item(OP_DELETE, 4'd15, '0, '0, 1'b0, 8'd0));
    // Fill every slot, all due together, repeating: tick hits the result cap.
    for (int i = 0; i < SLOT_COUNT; i++)
      send_item(make_item(OP_CREATE, 4'(i), 32'd0, 32'd100, 1'b1, 8'(i)));
    send_item(make_item(OP_TICK, 4'd0, '0, 32'd100, 1'b0, 8'd0));
    send_item(make_item(OP_TICK, 4'd0, '0, 32'd101, 1'b0, 8'd0));
    clock_now = 32'd101;

    // Pause the sender until every expected result has drained.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 40) calm <= 1'b1;
      it = random_item();
      if (it.opcode == OP_TICK && it.now > clock_now) clock_now = it.now;
      send_item(it);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/tqe_pkg.sv
src/tqe_cell.sv
src/timer_queue_expiry_engine.sv
tb/sv/tqe_checker.sv
tb/sv/tb_top.sv
